// ===== hw/rtl/bb3_pkg.sv =====
// Package for the 3x3 RGB box blur: shared types, constants and the divide-by-9 helper.
// No dependencies; every other file of the block but bb3_ram imports it.
package bb3_pkg;

    // Default line store depth (largest supported line width)
    localparam int BB3_MAX_WIDTH = 1024;

    // Configuration register layout
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 12'd480;
    localparam int MIN_DIM = 3;

    // Output queue: power-of-two depth, room for two results kept free per item
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
    localparam int OQ_LIMIT = OQ_DEPTH - 2;

    // floor(s / 9) = (s * 3641) >> 15, exact for s below 32768
    localparam int SUM_W      = 12;
    localparam int DIV9_RECIP = 3641;
    localparam int DIV9_SHIFT = 15;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Per-channel sum of one window column (three bytes)
    typedef struct packed {
        logic [9:0] r;
        logic [9:0] g;
        logic [9:0] b;
    } colsum_t;

    // Per-channel sum over a whole window
    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } sums_t;

    // One result item
    typedef struct packed {
        rgb_t pix;
        logic last;
    } result_t;

    // Per-item command from the position control to the datapath
    typedef struct packed {
        logic valid;
        logic write;   // pixel item: line stores get written
        logic yge1;    // middle line holds data
        logic yge2;    // upper line holds data
        logic col0;    // first column: window restarts
        logic emit1;   // full 3-column result
        logic emit2;   // right-edge 2-column result
        logic last;    // right-edge result is last of frame
        rgb_t pix;
    } cmd_t;

    // Result flags traveling down the datapath
    typedef struct packed {
        logic emit1;
        logic emit2;
        logic last;
    } flags_t;

    // Results pushed into the output queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    d0;
        result_t    d1;
    } push_t;

    function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
        logic [2*SUM_W-1:0] p;
        p = (2*SUM_W)'(s) * (2*SUM_W)'(DIV9_RECIP);
        return p[DIV9_SHIFT +: 8];
    endfunction

endpackage

// ===== hw/rtl/bb3_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bb3_ctl.sv =====
// Position control for the box blur: config registers, line/column counters,
// item acceptance with output credit, and the per-item command. Uses bb3_pkg.
module bb3_ctl
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = BB3_MAX_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  rgb_t                         in_pix,
    input  logic                         out_pop,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output cmd_t                         cmd,
    output logic [$clog2(MAX_WIDTH)-1:0] cmd_addr
);

    localparam int XW = $clog2(MAX_WIDTH);

    logic [FW_W-1:0]     fw_reg;
    logic [FH_W-1:0]     fh_reg;
    logic [XW-1:0]       x_reg, x_next;
    logic [FH_W-1:0]     y_reg, y_next;
    logic [OQ_CNT_W-1:0] used_reg, used_next;
    cmd_t                cmd_reg, cmd_next;
    logic [XW-1:0]       addr_reg;

    logic [XW-1:0]   wlast;
    logic [FH_W-1:0] h_eff;
    logic            y_drain, yge1, yge2, x_last, x0;
    logic            accept, active;
    logic [1:0]      n_res;

    // Effective frame size, clamped to the supported range
    always_comb
    begin
        if (32'(fw_reg) < MIN_DIM)
        begin
            wlast = XW'(MIN_DIM - 1);
        end
        else if (32'(fw_reg) > MAX_WIDTH)
        begin
            wlast = XW'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast = XW'(fw_reg - 11'd1);
        end
        h_eff = (32'(fh_reg) < MIN_DIM) ? FH_W'(MIN_DIM) : fh_reg;
    end

    // Position decode and acceptance
    always_comb
    begin
        y_drain = (y_reg >= h_eff);
        yge1    = (y_reg != '0);
        yge2    = (y_reg >= FH_W'(2));
        x_last  = (x_reg == wlast);
        x0      = (x_reg == '0);
        in_stall = (used_reg > OQ_CNT_W'(OQ_LIMIT));
        accept  = in_valid && !in_stall;
        // a pixel during drain, or a drain tick before it, is dropped
        active  = accept && (action == y_drain);
        n_res   = 2'(yge1 && !x0) + 2'(yge1 && x_last);
    end

    // Counter and credit next state
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        used_next = used_reg + OQ_CNT_W'(active ? n_res : 2'd0) - OQ_CNT_W'(out_pop);
        if (cfg_we)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (active)
        begin
            if (x_last)
            begin
                x_next = '0;
                y_next = y_drain ? '0 : y_reg + FH_W'(1);
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    // Command for the datapath, registered: it arrives in the cycle after the read issue
    always_comb
    begin
        cmd_next.valid = active;
        cmd_next.write = !action;
        cmd_next.yge1  = yge1;
        cmd_next.yge2  = yge2;
        cmd_next.col0  = x0;
        cmd_next.emit1 = yge1 && !x0;
        cmd_next.emit2 = yge1 && x_last;
        cmd_next.last  = y_drain;
        cmd_next.pix   = action ? '0 : in_pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= FW_RESET;
            fh_reg   <= FH_RESET;
            x_reg    <= '0;
            y_reg    <= '0;
            used_reg <= '0;
            cmd_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                endcase
            end
            x_reg    <= x_next;
            y_reg    <= y_next;
            used_reg <= used_next;
            cmd_reg  <= cmd_next;
        end
    end

    // Line store address travels with the command
    always_ff @(posedge clk)
    begin
        addr_reg <= x_reg;
    end

    assign col      = x_reg;
    assign cmd      = cmd_reg;
    assign cmd_addr = addr_reg;

endmodule

// ===== hw/rtl/bb3_blur.sv =====
// Blur datapath: line store write-back, column-sum window, window sums and divide by 9.
// Uses bb3_pkg.
module bb3_blur
    import bb3_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  rgb_t  upper_rd,
    input  rgb_t  middle_rd,
    output logic  line_we,
    output rgb_t  upper_wr,
    output rgb_t  middle_wr,
    output push_t push
);

    rgb_t    top, mid;
    colsum_t col_new;
    colsum_t win_reg [3];
    flags_t  s2_reg, s2_next, s3_reg;
    sums_t   sum1_reg, sum2_reg, sum1_next, sum2_next;
    result_t r1, r2;

    // Mask line stores that hold no data for this line yet
    always_comb
    begin
        top = cmd.yge2 ? upper_rd : '0;
        mid = cmd.yge1 ? middle_rd : '0;
        col_new.r = 10'(top.r) + 10'(mid.r) + 10'(cmd.pix.r);
        col_new.g = 10'(top.g) + 10'(mid.g) + 10'(cmd.pix.g);
        col_new.b = 10'(top.b) + 10'(mid.b) + 10'(cmd.pix.b);
    end

    // Read-modify-write: lines move up by one at this column
    assign line_we   = cmd.valid && cmd.write;
    assign upper_wr  = mid;
    assign middle_wr = cmd.pix;

    always_comb
    begin
        s2_next.emit1 = cmd.valid && cmd.emit1;
        s2_next.emit2 = cmd.valid && cmd.emit2;
        s2_next.last  = cmd.last;
    end

    // Window shift; the first column starts from an empty window
    always_ff @(posedge clk)
    begin
        if (cmd.valid)
        begin
            if (cmd.col0)
            begin
                win_reg[0] <= '0;
                win_reg[1] <= '0;
            end
            else
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
            end
            win_reg[2] <= col_new;
        end
    end

    // Window sums: all three columns, and the right two
    always_comb
    begin
        sum2_next.r = SUM_W'(win_reg[1].r) + SUM_W'(win_reg[2].r);
        sum2_next.g = SUM_W'(win_reg[1].g) + SUM_W'(win_reg[2].g);
        sum2_next.b = SUM_W'(win_reg[1].b) + SUM_W'(win_reg[2].b);
        sum1_next.r = sum2_next.r + SUM_W'(win_reg[0].r);
        sum1_next.g = sum2_next.g + SUM_W'(win_reg[0].g);
        sum1_next.b = sum2_next.b + SUM_W'(win_reg[0].b);
    end

    always_ff @(posedge clk)
    begin
        sum1_reg <= sum1_next;
        sum2_reg <= sum2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
            s3_reg <= s2_reg;
        end
    end

    // Divide by 9 and hand results to the output queue
    always_comb
    begin
        r1.pix.r = div9(sum1_reg.r);
        r1.pix.g = div9(sum1_reg.g);
        r1.pix.b = div9(sum1_reg.b);
        r1.last  = 1'b0;
        r2.pix.r = div9(sum2_reg.r);
        r2.pix.g = div9(sum2_reg.g);
        r2.pix.b = div9(sum2_reg.b);
        r2.last  = s3_reg.last;
        push.count = 2'(s3_reg.emit1) + 2'(s3_reg.emit2);
        push.d0    = s3_reg.emit1 ? r1 : r2;
        push.d1    = r2;
    end

endmodule

// ===== hw/rtl/bb3_fifo.sv =====
// Output queue for result items: up to two pushes and one pop per cycle.
// Uses bb3_pkg; overflow is prevented by the credit count in bb3_ctl.
module bb3_fifo
    import bb3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output logic    out_valid,
    output result_t out_data
);

    result_t             slot_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_reg, rd_reg;
    logic [OQ_CNT_W-1:0] cnt_reg;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_reg] <= push.d0;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[wr_reg + OQ_PTR_W'(1)] <= push.d1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + OQ_PTR_W'(push.count);
            rd_reg  <= rd_reg + OQ_PTR_W'(pop);
            cnt_reg <= cnt_reg + OQ_CNT_W'(push.count) - OQ_CNT_W'(pop);
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_reg];

endmodule

// ===== hw/rtl/box_blur_3x3_rgb.sv =====
// Top level of the streaming 3x3 RGB box blur.
// Uses bb3_pkg, bb3_ctl, bb3_ram, bb3_blur and bb3_fifo.
//
// One frame enters in raster order, one pixel item per clock while in_stall is low; each
// output is the per-channel sum of the in-frame 3x3 neighborhood divided by 9 (truncated),
// with out-of-frame neighbors taken as zero. The result for line y-1, column x-1 is
// produced by pixel (y, x); the line end adds the right-edge result. After the last
// line, frame_width drain items (action = 1) flush the bottom row; last_of_frame marks
// the final result. Drain items before that point and pixels during it are dropped.
// Two line stores (one read and one write port each, MAX_WIDTH entries) hold the
// previous lines; a new item can be taken every cycle while in_stall is low. A result
// passes the command, window and sum registers and the output queue. Every line after
// the first yields w results for its w items, two at the line end, so with the output
// never stalled the input is never stalled either; the 8-entry output queue holds the
// input back only while the output is stalled. No clearing pass after reset is needed.
// Writing frame_width or frame_height restarts the frame; write only while idle.
module box_blur_3x3_rgb
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = BB3_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [7:0]            in_red,
    input  logic [7:0]            in_green,
    input  logic [7:0]            in_blue,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_red,
    output logic [7:0]            out_green,
    output logic [7:0]            out_blue,
    output logic                  last_of_frame
);

    localparam int XW = $clog2(MAX_WIDTH);

    rgb_t          in_pix;
    logic [XW-1:0] col, cmd_addr;
    cmd_t          cmd;
    rgb_t          upper_rd, middle_rd, upper_wr, middle_wr;
    logic          line_we;
    push_t         push;
    logic          out_pop;
    result_t       out_data;

    assign in_pix  = '{r: in_red, g: in_green, b: in_blue};
    assign out_pop = out_valid && !out_stall;

    // Positions, acceptance and config
    bb3_ctl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .in_pix    (in_pix),
        .out_pop   (out_pop),
        .col       (col),
        .cmd       (cmd),
        .cmd_addr  (cmd_addr)
    );

    // Line stores, read at the incoming column, written in the following cycle
    bb3_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk     (clk),
        .wr_en   (line_we),
        .wr_addr (cmd_addr),
        .wr_data (upper_wr),
        .rd_addr (col),
        .rd_data (upper_rd)
    );

    bb3_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk     (clk),
        .wr_en   (line_we),
        .wr_addr (cmd_addr),
        .wr_data (middle_wr),
        .rd_addr (col),
        .rd_data (middle_rd)
    );

    // Window and arithmetic
    bb3_blur u_blur (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .upper_rd  (upper_rd),
        .middle_rd (middle_rd),
        .line_we   (line_we),
        .upper_wr  (upper_wr),
        .middle_wr (middle_wr),
        .push      (push)
    );

    // Output queue
    bb3_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_pop),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign out_red       = out_data.pix.r;
    assign out_green     = out_data.pix.g;
    assign out_blue      = out_data.pix.b;
    assign last_of_frame = out_data.last;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the box_blur_3x3_rgb streaming 3x3 RGB blur.
// Depends on bb3_pkg and the box_blur_3x3_rgb RTL. A driver feeds queued pixel and
// drain items, a scoreboard predicts every blurred pixel and checks the output stream.
module testbench;
    import bb3_pkg::*;

    localparam logic ACT_PIXEL      = 1'b0;
    localparam logic ACT_DRAIN      = 1'b1;
    localparam int   RANDOM_ITEMS   = 160;
    localparam int   SETTLE_CYCLES  = 12;
    localparam int   MAX_REPORTS    = 10;
    localparam longint CYCLE_LIMIT  = 4000000;

    typedef struct packed {
        logic act;
        rgb_t pix;
    } blur_item_t;

    // DUT ports
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  action = ACT_PIXEL;
    logic [7:0]            in_red = '0;
    logic [7:0]            in_green = '0;
    logic [7:0]            in_blue = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic                  last_of_frame;

    // Stimulus and scoreboard
    blur_item_t frame_items[$];
    result_t    blurred_due[$];
    blur_item_t head_item;
    result_t    want;
    int         gap_left = 0;
    int         stall_run = 0;
    bit         quiet = 1'b1;
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         noise_pct = 0;
    int         bad_count = 0;
    int         results_seen = 0;
    longint     cycle_count = 0;

    // Predictor state: geometry registers, line stores, window, positions
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    rgb_t            row_above[BB3_MAX_WIDTH];
    rgb_t            row_prev[BB3_MAX_WIDTH];
    rgb_t            nbhd[9];    // row * 3 + column, row 0 on top
    int unsigned     in_x;
    int unsigned     in_y;
    int unsigned     out_x;
    int unsigned     out_y;

    box_blur_3x3_rgb u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .in_red        (in_red),
        .in_green      (in_green),
        .in_blue       (in_blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .last_of_frame (last_of_frame)
    );

    always #5 clk = ~clk;

    // Effective geometry: registers are clamped to the supported range
    function automatic int unsigned geom_w();
        if (width_reg < MIN_DIM)
            return MIN_DIM;
        if (width_reg > BB3_MAX_WIDTH)
            return BB3_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned geom_h();
        if (height_reg < MIN_DIM)
            return MIN_DIM;
        return height_reg;
    endfunction

    function automatic void frame_restart();
        int i;
        for (i = 0; i < 9; i++)
            nbhd[i] = '0;
        in_x = 0;
        in_y = 0;
        out_x = 0;
        out_y = 0;
    endfunction

    function automatic void set_geometry(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_FRAME_WIDTH)
        begin
            width_reg = data[FW_W-1:0];
            frame_restart();
        end
        else if (idx == CFG_FRAME_HEIGHT)
        begin
            height_reg = data[FH_W-1:0];
            frame_restart();
        end
    endfunction

    // Average window columns first_col..2, then step the output position
    function automatic result_t blur_result(int first_col);
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        int          r;
        int          c;
        result_t     res;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (r = 0; r < 3; r++)
        begin
            for (c = first_col; c < 3; c++)
            begin
                sum_r += nbhd[r * 3 + c].r;
                sum_g += nbhd[r * 3 + c].g;
                sum_b += nbhd[r * 3 + c].b;
            end
        end
        res.pix.r = 8'(sum_r / 9);
        res.pix.g = 8'(sum_g / 9);
        res.pix.b = 8'(sum_b / 9);
        res.last  = (out_y == geom_h() - 1) && (out_x == geom_w() - 1);
        out_x++;
        if (out_x >= geom_w())
        begin
            out_x = 0;
            out_y++;
            if (out_y >= geom_h())
                out_y = 0;
        end
        return res;
    endfunction

    // One accepted item: update line stores and window, queue the blurred pixels it yields
    function automatic void blur_step(logic act, rgb_t pix_in);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int          r;
        logic        drain;
        rgb_t        px;
        rgb_t        above;
        rgb_t        mid;
        w = geom_w();
        h = geom_h();
        x = in_x;
        y = in_y;
        drain = (act == ACT_DRAIN);
        // drain during pixel lines, or pixel during the flush line: dropped
        if (drain != (y >= h))
            return;
        px    = drain ? rgb_t'(0) : pix_in;
        above = (y >= 2) ? row_above[x] : rgb_t'(0);
        mid   = (y >= 1) ? row_prev[x] : rgb_t'(0);
        if (!drain)
        begin
            row_above[x] = mid;
            row_prev[x]  = px;
        end
        for (r = 0; r < 3; r++)
        begin
            if (x == 0)
            begin
                nbhd[r * 3 + 1] = '0;
                nbhd[r * 3 + 2] = '0;
            end
            nbhd[r * 3]     = nbhd[r * 3 + 1];
            nbhd[r * 3 + 1] = nbhd[r * 3 + 2];
            nbhd[r * 3 + 2] = (r == 0) ? above : ((r == 1) ? mid : px);
        end
        if (y >= 1 && x >= 1)
            blurred_due.push_back(blur_result(0));
        if (y >= 1 && x == w - 1)
            blurred_due.push_back(blur_result(1));
        if (x == w - 1)
        begin
            in_x = 0;
            if (y >= h)
                frame_restart();
            else
                in_y = y + 1;
        end
        else
        begin
            in_x = x + 1;
        end
    endfunction

    function automatic void flag_error(string msg);
        bad_count++;
        if (bad_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 8'h00;
        if (roll == 1)
            return 8'hff;
        return 8'($urandom_range(255));
    endfunction

    function automatic void push_item(logic act, rgb_t pix);
        blur_item_t item;
        item.act = act;
        item.pix = pix;
        frame_items.push_back(item);
    endfunction

    // Input driver: next queued item once the current one is taken, random gaps after it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (frame_items.size() != 0)
            begin
                head_item = frame_items.pop_front();
                in_valid  <= 1'b1;
                action    <= head_item.act;
                in_red    <= head_item.pix.r;
                in_green  <= head_item.pix.g;
                in_blue   <= head_item.pix.b;
                gap_left  <= (quiet || $urandom_range(99) >= gap_pct) ? 0 : idle_len();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output backpressure in runs of random length
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run != 0)
        begin
            stall_run <= stall_run - 1;
        end
        else if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
            stall_run <= idle_len();
        end
    end

    // Monitor: track register writes and accepted items, check every accepted result
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            frame_restart();
        end
        else
        begin
            if (cfg_we)
                set_geometry(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                blur_step(action, {in_red, in_green, in_blue});
            if (out_valid && !out_stall)
            begin
                if (blurred_due.size() == 0)
                begin
                    flag_error($sformatf("result %0d not expected: rgb %02h %02h %02h last %0b",
                                         results_seen, out_red, out_green, out_blue,
                                         last_of_frame));
                end
                else
                begin
                    want = blurred_due.pop_front();
                    if (out_red !== want.pix.r || out_green !== want.pix.g ||
                        out_blue !== want.pix.b || last_of_frame !== want.last)
                        flag_error($sformatf({"result %0d: expected rgb %02h %02h %02h last %0b,",
                                              " got rgb %02h %02h %02h last %0b"},
                                             results_seen, want.pix.r, want.pix.g, want.pix.b,
                                             want.last, out_red, out_green, out_blue,
                                             last_of_frame));
                end
                results_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Wait until everything sent has come out, then let the pipeline empty
    task automatic settle();
        while (frame_items.size() != 0 || in_valid || blurred_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Queue one frame plus its flush line; stray items of the wrong kind mixed in,
    // optional early stop (cut) and a full pause part way (pause_at)
    task automatic queue_frame(input int w, input int h, input int cut, input int pause_at,
                               output int sent);
        int x;
        int y;
        sent = 0;
        for (y = 0; y <= h; y++)
        begin
            for (x = 0; x < w; x++)
            begin
                if (cut != 0 && sent == cut)
                    return;
                if (pause_at != 0 && sent == pause_at)
                    settle();
                if ($urandom_range(99) < noise_pct)
                    push_item((y < h) ? ACT_DRAIN : ACT_PIXEL,
                              {rand_byte(), rand_byte(), rand_byte()});
                push_item((y < h) ? ACT_PIXEL : ACT_DRAIN,
                          {rand_byte(), rand_byte(), rand_byte()});
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [23:0] edge_pix[9];
        int          i;
        int          f;
        int          w;
        int          h;
        int          frames;
        int          cut;
        int          pause;
        int          phase;
        int          sel;
        int          sent;
        int          random_count;
        int unsigned wreg;
        int unsigned hreg;

        edge_pix = '{24'h000000, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffffff,
                     24'h808080, 24'h7f7f7f, 24'h010203, 24'hfefdfc};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: smallest frame, saturated values, stray drain and stray pixel
        quiet     = 1'b0;
        gap_pct   = 30;
        stall_pct = 30;
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(MIN_DIM));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(MIN_DIM));
        push_item(ACT_DRAIN, 24'h5a5a5a);            // drain before the flush: ignored
        for (i = 0; i < 9; i++)
            push_item(ACT_PIXEL, 24'hffffff);
        push_item(ACT_DRAIN, 24'h000000);
        push_item(ACT_PIXEL, 24'h123456);            // pixel during the flush: dropped
        push_item(ACT_DRAIN, 24'hffffff);
        push_item(ACT_DRAIN, 24'ha5c3e1);
        // next frame starts right after the previous flush
        for (i = 0; i < 9; i++)
            push_item(ACT_PIXEL, edge_pix[i]);
        for (i = 0; i < 3; i++)
            push_item(ACT_DRAIN, 24'h000000);
        settle();

        // Random phases: one or both geometry registers rewritten each time, small frames, some cut short
        phase = 0;
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            quiet     = ($urandom_range(3) == 0);
            gap_pct   = $urandom_range(10, 50);
            stall_pct = $urandom_range(10, 60);
            noise_pct = $urandom_range(0, 6);

            sel = $urandom_range(99);
            if (sel < 70)
                wreg = $urandom_range(3, 10);
            else if (sel < 80)
                wreg = $urandom_range(0, 2);
            else if (sel < 90)
                wreg = $urandom_range(11, 24);
            else
                wreg = 12'h800 | $urandom_range(3, 10);   // top bit is not stored
            sel = $urandom_range(99);
            if (sel < 70)
                hreg = $urandom_range(3, 7);
            else if (sel < 85)
                hreg = $urandom_range(0, 2);
            else
                hreg = $urandom_range(8, 12);

            sel = $urandom_range(9);
            if (sel != 0 || phase == 0)
                write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(wreg));
            if (sel != 1 || phase == 0)
                write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(hreg));
            w = geom_w();
            h = geom_h();

            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++)
            begin
                pause = (phase == 0 && f == 0) ? (w * h) / 2 : 0;
                cut = 0;
                if (pause == 0 && f == frames - 1 && $urandom_range(4) == 0)
                    cut = $urandom_range(1, w * h);
                queue_frame(w, h, cut, pause, sent);
                random_count += sent;
            end
            settle();
            phase++;
        end

        // All-ones width and zero height, both clamped; widest line, frame abandoned
        // early in the second line
        quiet     = 1'b0;
        gap_pct   = 10;
        stall_pct = 20;
        noise_pct = 1;
        write_reg(CFG_FRAME_WIDTH, 12'h7ff);
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(0));
        queue_frame(geom_w(), geom_h(), geom_w() + 8, 0, sent);
        settle();

        if (bad_count == 0 && blurred_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
